// ----- rtl/core/max_stack_core_assert.svh -----
// Assertion macros used by the max stack checker file.
`ifndef MAX_STACK_CORE_ASSERT_SVH
`define MAX_STACK_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MXS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("max stack assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define MXS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("max stack assertion failed");

`endif

// ----- rtl/core/mxs_pkg.sv -----
// Types and constants shared by the max stack files.
package mxs_pkg;

    // Fixed port field widths
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 3;
    localparam int RESULT_W    = 32;
    localparam int DEPTH_NOW_W = 7;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_PAD_W   = OUT_DATA_W - RESULT_W - DEPTH_NOW_W;
    localparam int OUT_USER_W  = 2;

    // Operation codes
    typedef enum logic [IN_USER_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_TOP      = 3'd2,
        OP_PEEK_MAX = 3'd3,
        OP_POP_MAX  = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [OUT_USER_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/mxs_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mxs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/max_stack_core.sv -----
// Bounded signed-word stack with peek-max and pop-max, sequenced over one RAM.
//
// A bounded stack of DEPTH signed DATA_WIDTH-bit words that can also report
// and remove its largest entry. The input tuser carries the operation (push,
// pop, top, peek max, pop max) and tdata the value to push. Each item gives
// one result: value, status (ok, empty, full) and the depth after the item.
// The block takes one item at a time and drops tready while it works. All
// entries live in one RAM with a single registered read port, and that port
// sets the timing: push, errors and unknown operations go straight to the
// result, pop and top first read the top entry, peek max reads every entry
// from the top down, and pop max does the same scan and then moves the
// entries above the removed maximum down one per cycle. A finished result
// waits in an output register, so the next item is accepted while the
// previous result is still pending. No clearing pass is needed after reset.
module max_stack_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input items
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [mxs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // [31:0] push_value
    input  logic [mxs_pkg::IN_USER_W-1:0]  i_s_axis_tuser,  // [2:0] op
    // Result items
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [mxs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // [31:0] result_value,
                                                            // [38:32] depth_now, [39] zero
    output logic [mxs_pkg::OUT_USER_W-1:0] o_m_axis_tuser   // [1:0] status
);

    import mxs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                        r_state, n_state;
    t_op                           r_op, n_op;
    t_status                       r_res_status, n_res_status;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [AW-1:0]                 r_addr, n_addr;
    logic                          r_first, n_first;
    logic signed [DATA_WIDTH-1:0]  r_best_val, n_best_val;
    logic [AW-1:0]                 r_best_idx, n_best_idx;
    logic signed [DATA_WIDTH-1:0]  r_res_val, n_res_val;
    logic                          r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]         r_out_data, n_out_data;
    logic [OUT_USER_W-1:0]         r_out_user, n_out_user;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [DATA_WIDTH-1:0]         ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [DATA_WIDTH-1:0]         ram_rdata;

    logic [CW-1:0]                 w_top;
    logic [AW-1:0]                 w_top_a;
    logic signed [DATA_WIDTH-1:0]  w_rd;
    logic signed [DATA_WIDTH-1:0]  w_push;
    logic                          w_take;
    logic signed [DATA_WIDTH-1:0]  w_scan_val;
    logic [AW-1:0]                 w_scan_idx;

    // Entry storage
    mxs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Top slot and the shared compare for the max scan
    assign w_top      = r_cnt - CW'(1);
    assign w_top_a    = w_top[AW-1:0];
    assign w_rd       = signed'(ram_rdata);
    assign w_push     = DATA_WIDTH'(signed'(i_s_axis_tdata));
    assign w_take     = r_first || (w_rd > r_best_val);
    assign w_scan_val = w_take ? w_rd : r_best_val;
    assign w_scan_idx = w_take ? r_addr : r_best_idx;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_res_status <= n_res_status;
        r_addr       <= n_addr;
        r_first      <= n_first;
        r_best_val   <= n_best_val;
        r_best_idx   <= n_best_idx;
        r_res_val    <= n_res_val;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_res_status = r_res_status;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_first      = r_first;
        n_best_val   = r_best_val;
        n_best_idx   = r_best_idx;
        n_res_val    = r_res_val;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        ram_we       = 1'b0;
        ram_waddr    = r_addr - AW'(1);
        ram_wdata    = ram_rdata;
        ram_raddr    = r_addr;

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op         = t_op'(i_s_axis_tuser);
                    n_res_val    = '0;
                    n_res_status = STAT_OK;
                    n_state      = ST_DONE;
                    case (t_op'(i_s_axis_tuser))
                        OP_PUSH: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[AW-1:0];
                                ram_wdata = w_push;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        OP_POP, OP_TOP: begin
                            if (r_cnt == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                ram_raddr = w_top_a;
                                n_state   = ST_READ;
                            end
                        end
                        OP_PEEK_MAX, OP_POP_MAX: begin
                            if (r_cnt == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                ram_raddr = w_top_a;
                                n_addr    = w_top_a;
                                n_first   = 1'b1;
                                n_state   = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Take the top entry
            ST_READ: begin
                n_res_val = w_rd;
                if (r_op == OP_POP) begin
                    n_cnt = w_top;
                end
                n_state = ST_DONE;
            end
            // Walk down from the top; strict greater keeps the topmost maximum
            ST_SCAN: begin
                n_best_val = w_scan_val;
                n_best_idx = w_scan_idx;
                n_first    = 1'b0;
                if (r_addr == '0) begin
                    n_res_val = w_scan_val;
                    if (r_op == OP_POP_MAX) begin
                        if (w_scan_idx == w_top_a) begin
                            n_cnt   = w_top;
                            n_state = ST_DONE;
                        end else begin
                            ram_raddr = w_scan_idx + AW'(1);
                            n_addr    = w_scan_idx + AW'(1);
                            n_state   = ST_SHIFT;
                        end
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    ram_raddr = r_addr - AW'(1);
                    n_addr    = r_addr - AW'(1);
                end
            end
            // Move each entry above the removed one down by one slot
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr - AW'(1);
                ram_wdata = ram_rdata;
                if (r_addr == w_top_a) begin
                    n_cnt   = w_top;
                    n_state = ST_DONE;
                end else begin
                    ram_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                end
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, DEPTH_NOW_W'(r_cnt),
                                   RESULT_W'(r_res_val)};
                    n_out_user  = r_res_status;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Take no item while reset is held
    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/core/mxs_chk.sv -----
// Port-level checker for the max stack core, with its bind statement.
`include "max_stack_core_assert.svh"

module mxs_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [mxs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // [31:0] result_value,
                                                           // [38:32] depth_now, [39] zero
    input logic [mxs_pkg::OUT_USER_W-1:0] o_m_axis_tuser   // [1:0] status
);

    import mxs_pkg::*;

    logic w_out_stall;
    logic w_in_take;
    logic w_out_empty;
    logic w_out_zero;

    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_in_take   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_empty = o_m_axis_tvalid && (o_m_axis_tuser == STAT_EMPTY);
    assign w_out_zero  = (o_m_axis_tdata[RESULT_W +: DEPTH_NOW_W] == '0) &&
                         (o_m_axis_tdata[RESULT_W-1:0] == '0);

    // Hold a stalled result
    `MXS_ASSERT_NEXT(a_out_hold, w_out_stall, o_m_axis_tvalid)
    `MXS_ASSERT_NEXT(a_out_stable, w_out_stall, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // Go busy in the cycle after taking an item
    `MXS_ASSERT_NEXT(a_busy_after_accept, w_in_take, !o_s_axis_tready)

    // An empty error reports an empty stack and a zero value
    `MXS_ASSERT_SAME(a_empty_result, w_out_empty, w_out_zero)

endmodule

bind max_stack_core mxs_chk u_mxs_chk (.*);
